// ----- design/flbt_pkg.sv -----
// Shared types and codes for the failed-login ban table.
`default_nettype none

package flbt_pkg;

	// Request codes carried on the input tuser.
	localparam logic [1:0] REQ_CHECK   = 2'd0;
	localparam logic [1:0] REQ_FAIL    = 2'd1;
	localparam logic [1:0] REQ_SUCCESS = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_FAILURE_LIMIT = 1'b0;
	localparam logic CFG_BAN_SECONDS   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [15:0] FAILURE_LIMIT_RESET = 16'd5;
	localparam logic [31:0] BAN_SECONDS_RESET   = 32'd300;

	// Field widths.
	localparam int ADDR_W  = 32;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 16;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 24;

	// Queued request between the front and the back.
	typedef struct packed {
		logic              known;
		logic [1:0]        req;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] now;
	} item_t;

	// One table entry.
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  ban_end;
	} entry_t;

	// One result item.
	typedef struct packed {
		logic               allowed;
		logic               found;
		logic               added;
		logic               dropped;
		logic               banned;
		logic [COUNT_W-1:0] fails;
	} result_t;

	// Configuration values seen by the back end.
	typedef struct packed {
		logic [COUNT_W-1:0] failure_limit;
		logic [TIME_W-1:0]  ban_seconds;
	} cfg_t;

endpackage

`default_nettype wire

// ----- design/flbt_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module flbt_front
	import flbt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        in_req,
	input  wire logic [ADDR_W-1:0] in_addr,
	input  wire logic [TIME_W-1:0] in_now,
	output logic                   q_valid,
	output item_t                  q_item,
	input  wire logic              q_pop
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	item_t      new_item;

	assign in_ready = (fill_q != 2'd2);
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	// Mark whether the request code names a known operation.
	always_comb begin
		new_item.req  = in_req;
		new_item.addr = in_addr;
		new_item.now  = in_now;
		case (in_req) inside
			REQ_CHECK, REQ_FAIL, REQ_SUCCESS: new_item.known = 1'b1;
			default:                          new_item.known = 1'b0;
		endcase
	end

	// Queue payload slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/flbt_back.sv -----
// Back end: scans the entry memory, applies the update and holds the result.
`default_nettype none

module flbt_back
	import flbt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic q_valid,
	input  wire item_t q_item,
	output logic      q_pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   out_result
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	entry_t          mem [TABLE_ENTRIES];
	entry_t          rd_q;
	logic [1:0]      state_q;
	item_t           item_q;
	logic [IW-1:0]   idx_q;
	logic            hit_q;
	logic [CW-1:0]   used_q;
	logic            out_valid_q;
	result_t         out_q;

	logic            out_free;
	logic            start;
	logic            scan_hit;
	logic            scan_last;
	logic [CW-1:0]   scan_next;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic [IW-1:0]   wr_idx;
	entry_t          wr_ent;
	logic            grow;
	result_t         upd_res;
	logic [COUNT_W-1:0] inc_count;
	logic [TIME_W:0]    end_sum;
	logic [TIME_W-1:0]  end_sat;
	logic            load_out;
	result_t         load_res;

	assign out_free   = !out_valid_q || out_ready;
	assign start      = (state_q == ST_IDLE) && q_valid && out_free;
	assign q_pop      = start;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	// Scan compare on the entry read in the previous cycle.
	assign scan_hit  = (rd_q.addr == item_q.addr);
	assign scan_next = CW'(idx_q) + CW'(1);
	assign scan_last = (scan_next == used_q);

	// One read per cycle walks the used entries in order.
	assign rd_en   = (start && q_item.known && (used_q != '0)) ||
			((state_q == ST_SCAN) && !scan_hit && !scan_last);
	assign rd_addr = (state_q == ST_IDLE) ? '0 : IW'(scan_next);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Saturating arithmetic for the update step.
	assign inc_count = (rd_q.count == '1) ? rd_q.count : rd_q.count + COUNT_W'(1);
	assign end_sum   = {1'b0, item_q.now} + {1'b0, cfg.ban_seconds};
	assign end_sat   = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];

	// Decide the result and the table write for the current request.
	always_comb begin
		upd_res       = '0;
		upd_res.found = hit_q;
		wr_en         = 1'b0;
		wr_idx        = idx_q;
		wr_ent        = rd_q;
		grow          = 1'b0;
		case (item_q.req)
			REQ_CHECK: begin
				upd_res.allowed = 1'b1;
				if (hit_q) begin
					upd_res.fails = rd_q.count;
					if (rd_q.ban_end > item_q.now) begin
						upd_res.allowed = 1'b0;
					end else if (rd_q.ban_end != '0) begin
						wr_en          = 1'b1;
						wr_ent.count   = '0;
						wr_ent.ban_end = '0;
						upd_res.fails  = '0;
					end
				end
			end
			REQ_FAIL: begin
				if (hit_q) begin
					wr_en         = 1'b1;
					wr_ent.count  = inc_count;
					upd_res.fails = inc_count;
					if (inc_count >= cfg.failure_limit) begin
						wr_ent.ban_end = end_sat;
						upd_res.banned = 1'b1;
					end
				end else if (used_q < FULL_COUNT) begin
					wr_en          = 1'b1;
					wr_idx         = IW'(used_q);
					wr_ent.addr    = item_q.addr;
					wr_ent.count   = COUNT_W'(1);
					wr_ent.ban_end = '0;
					grow           = 1'b1;
					upd_res.added  = 1'b1;
					upd_res.fails  = COUNT_W'(1);
				end else begin
					upd_res.dropped = 1'b1;
				end
			end
			REQ_SUCCESS: begin
				if (hit_q) begin
					wr_en          = 1'b1;
					wr_ent.count   = '0;
					wr_ent.ban_end = '0;
				end
			end
			default: begin
				upd_res = '0;
			end
		endcase
		if (state_q != ST_UPDATE) begin
			wr_en = 1'b0;
			grow  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_ent;
		end
	end

	// An unknown request answers zero at once; others answer after the update.
	assign load_out = (start && !q_item.known) || (state_q == ST_UPDATE);
	assign load_res = (state_q == ST_UPDATE) ? upd_res : '0;

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= load_res;
		end
	end

	// Sequencer, fill count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (grow) begin
				used_q <= used_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start && q_item.known) begin
						hit_q <= 1'b0;
						idx_q <= '0;
						state_q <= (used_q == '0) ? ST_UPDATE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else if (scan_last) begin
						state_q <= ST_UPDATE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The request is captured when it leaves the queue.
	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= q_item;
		end
	end

endmodule

`default_nettype wire

// ----- design/failed_login_ban_table_core.sv -----
// Top level of the failed-login ban table.
`default_nettype none

// Keeps up to TABLE_ENTRIES client addresses with a failure count and a ban
// end time, and answers check, failure and success requests with one result
// each. Requests enter a two-deep queue, so until it is full the input keeps
// accepting while the table engine works and while a result waits at the
// output. A request is served by a linear scan through the single read port
// of the entry memory, one entry per cycle, that stops at a hit or after the
// last used entry, followed by an update step; an unknown request code skips
// both and answers with an all-zero result. The memory needs no clearing
// after reset: only entries below the fill count are ever read.
module failed_login_ban_table_core
	import flbt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// Fields from bit 0: client_addr[31:0], now_seconds[63:32].
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: req_type[1:0].
	input  wire logic [1:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// Fields from bit 0: allowed, entry_found, entry_added, dropped_full,
	// ban_started, failures_after[20:5], zero fill [23:21].
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [31:0]           cfg_data
);

	cfg_t    cfg_q;
	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	result_t result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.failure_limit <= FAILURE_LIMIT_RESET;
			cfg_q.ban_seconds   <= BAN_SECONDS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FAILURE_LIMIT: cfg_q.failure_limit <= cfg_data[COUNT_W-1:0];
				CFG_BAN_SECONDS:   cfg_q.ban_seconds   <= cfg_data[TIME_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	flbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (s_axis_tuser),
		.in_addr  (s_axis_tdata[ADDR_W-1:0]),
		.in_now   (s_axis_tdata[IN_DATA_W-1:ADDR_W]),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	flbt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	// Pack the result fields, lowest field first.
	assign m_axis_tdata = {3'b000, result.fails, result.banned, result.dropped,
			result.added, result.found, result.allowed};

endmodule

`default_nettype wire

// ----- design/flbt_checker.sv -----
// Port-level checker for the failed-login ban table, with its bind.
`default_nettype none

module flbt_checker
	import flbt_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Requests accepted whose results are not yet taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Every result answers an accepted request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 3'd0)
		else $error("result without a pending request");

	// The queue, the engine and the output register bound what is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many requests in flight");

	// Result flags agree with each other and with the failure count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			!(m_axis_tdata[1] && m_axis_tdata[2]) &&
			!(m_axis_tdata[0] && m_axis_tdata[4]) &&
			(!m_axis_tdata[3] || m_axis_tdata[20:5] == 16'd0) &&
			(!m_axis_tdata[2] || m_axis_tdata[20:5] == 16'd1))
		else $error("inconsistent result flags");

endmodule

bind failed_login_ban_table_core flbt_checker u_flbt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
